[sv/csr_local_first_neighbor_sampler_core_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the CSR neighbor sampler
// Concurrent assertion shorthands; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef CSR_LOCAL_FIRST_NEIGHBOR_SAMPLER_CORE_MACROS_SVH
`define CSR_LOCAL_FIRST_NEIGHBOR_SAMPLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CSRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CSRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/csrs_pkg.sv]
// ---------------------------------------------------------------------------
// CSR neighbor sampler package
// Word types, register map and default sizes.
// ---------------------------------------------------------------------------
package csrs_pkg;

    localparam int unsigned DEF_MAX_NODES = 4096;
    localparam int unsigned DEF_MAX_EDGES = 65536;

    localparam int unsigned ROFF_W = 31;
    localparam int unsigned RS_W   = 17;
    localparam int unsigned LC_W   = 17;

    typedef enum logic [1:0] {
        ACT_ROW_WR  = 2'd0,
        ACT_EDGE_WR = 2'd1,
        ACT_SPLIT   = 2'd2,
        ACT_SAMPLE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REG_PARTITION_ID = 2'd0,
        REG_LOCAL_RATIO  = 2'd1,
        REG_NODE_COUNT   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]        action;
        logic [12:0]       node;
        logic [16:0]       row_start;
        logic [15:0]       edge_slot;
        logic [11:0]       neighbor;
        logic [7:0]        owner;
        logic [15:0]       rand_select;
        logic [ROFF_W-1:0] rand_offset;
    } t_in_word;

    typedef struct packed {
        logic [11:0] sampled_node;
        logic [7:0]  sampled_owner;
        logic        invalid;
    } t_out_word;

    typedef struct packed {
        logic [11:0] neighbor;
        logic [7:0]  owner;
    } t_edge;

endpackage

[sv/csr_local_first_neighbor_sampler_core.sv]
// ---------------------------------------------------------------------------
// CSR local-first neighbor sampler
// Graph store in CSR form with partition pass and random neighbor sampling.
// ---------------------------------------------------------------------------
// One word in, at most one word out (samples only). Row-start writes and edge
// writes are done in the cycle their word is accepted. A sample does two
// row-start reads, then a 31-step restoring remainder unit (one bit per cycle)
// reduces rand_offset by the candidate count, then one edge memory read. The
// partition pass walks every active node: two row-start reads, then a local
// edge is kept and a remote one is swapped, all through the single edge memory
// port. After reset the local-count memory is cleared one entry a cycle; no
// input word is taken until that sweep ends, APB writes are taken meanwhile.
// A finished result sits in the output register while the next word runs.
`include "csr_local_first_neighbor_sampler_core_macros.svh"

module csr_local_first_neighbor_sampler_core #(
    parameter int unsigned MAX_NODES = csrs_pkg::DEF_MAX_NODES,
    parameter int unsigned MAX_EDGES = csrs_pkg::DEF_MAX_EDGES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  csrs_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output csrs_pkg::t_out_word  o_out_word,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import csrs_pkg::*;

    localparam int unsigned NW  = $clog2(MAX_NODES + 1); // holds node counts
    localparam int unsigned NIW = $clog2(MAX_NODES);     // local-count index
    localparam int unsigned RIW = $clog2(MAX_NODES + 1); // row-start index
    localparam int unsigned EW  = $clog2(MAX_EDGES);     // edge index
    localparam int unsigned LW  = $clog2(MAX_EDGES + 1); // edge positions

    typedef enum logic [15:0] {
        S_CLR  = 16'h0001,
        S_IDLE = 16'h0002,
        S_SA   = 16'h0004,
        S_SB   = 16'h0008,
        S_SC   = 16'h0010,
        S_DIV  = 16'h0020,
        S_SE   = 16'h0040,
        S_SF   = 16'h0080,
        S_OUT  = 16'h0100,
        S_PA   = 16'h0200,
        S_PB   = 16'h0400,
        S_PC   = 16'h0800,
        S_PL   = 16'h1000,
        S_PD   = 16'h2000,
        S_PE   = 16'h4000,
        S_PF   = 16'h8000
    } t_state;

    // ---- memories ----
    logic [RS_W-1:0] rs_mem [MAX_NODES+1];
    t_edge           e_mem  [MAX_EDGES];
    logic [LC_W-1:0] lc_mem [MAX_NODES];

    // ---- registers ----
    t_state          r_state, n_state;
    logic [7:0]      r_pid;
    logic [16:0]     r_ratio;
    logic [12:0]     r_ncnt;
    t_in_word        r_in;
    logic [NW-1:0]   r_n;
    logic [LW-1:0]   r_start, r_deg, r_lo, r_hi, r_div_d, r_rem;
    logic [ROFF_W-1:0] r_q;
    logic [4:0]      r_cnt;
    t_edge           r_adata;
    t_out_word       r_res, r_out;
    logic            r_out_valid;
    logic [RS_W-1:0] r_rs_rd;
    logic [LC_W-1:0] r_lc_rd;
    t_edge           r_e_rd;

    // ---- derived values ----
    logic [31:0]     act32, node32, slot32, n32;
    logic [NW-1:0]   active;
    logic            in_acc, node_bad, out_load;
    logic [LW-1:0]   end_c, deg_c, cand_c, a_addr, b_addr, pick;
    logic [31:0]     lc32, deg32;
    logic [LW:0]     div_t;
    logic [LW-1:0]   rem_c;

    // row-start memory port
    logic            rs_re, rs_we;
    logic [RIW-1:0]  rs_ra, rs_wa;
    // edge memory port
    logic            e_re, e_we;
    logic [EW-1:0]   e_ra, e_wa;
    t_edge           e_wd;
    // local-count memory port
    logic            lc_re, lc_we;
    logic [NIW-1:0]  lc_ra, lc_wa;
    logic [LC_W-1:0] lc_wd;

    function automatic logic [LW-1:0] clamp_edge(input logic [RS_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 > MAX_EDGES) v32 = MAX_EDGES;
        return v32[LW-1:0];
    endfunction

    assign act32    = (32'(r_ncnt) > MAX_NODES) ? MAX_NODES : 32'(r_ncnt);
    assign active   = act32[NW-1:0];
    assign node32   = 32'(i_in_word.node);
    assign slot32   = 32'(i_in_word.edge_slot);
    assign n32      = 32'(r_n);
    assign in_acc   = i_in_valid && o_in_ready;
    assign node_bad = node32 >= act32;
    assign out_load = !r_out_valid || i_out_ready;

    // row bounds from the end value just read
    assign end_c = clamp_edge(r_rs_rd);
    assign deg_c = (end_c > r_start) ? end_c - r_start : '0;

    // candidate count: local count capped at degree, unless the draw says any
    assign lc32  = 32'(r_lc_rd);
    assign deg32 = 32'(deg_c);
    always_comb begin
        cand_c = (lc32 > deg32) ? deg_c : r_lc_rd[LW-1:0] ;
        if (LW > LC_W && lc32 <= deg32) cand_c = LW'(r_lc_rd);
        if (!((17'(r_in.rand_select) < r_ratio) && (cand_c != '0))) cand_c = deg_c;
    end

    // one restoring step of the remainder unit
    assign div_t = {r_rem, r_q[ROFF_W-1]};
    assign rem_c = (div_t >= {1'b0, r_div_d}) ? LW'(div_t - {1'b0, r_div_d})
                                              : div_t[LW-1:0];

    assign a_addr = r_start + r_lo;
    assign b_addr = r_start + r_hi - LW'(1);
    assign pick   = r_start + r_rem;

    // ---- memory port control ----
    always_comb begin
        logic [31:0] ri;
        rs_re = 1'b0; rs_ra = '0;
        rs_we = 1'b0; rs_wa = node32[RIW-1:0];
        e_re  = 1'b0; e_ra  = '0;
        e_we  = 1'b0; e_wa  = slot32[EW-1:0];
        e_wd  = '{neighbor: i_in_word.neighbor, owner: i_in_word.owner};
        lc_re = 1'b0; lc_ra = '0;
        lc_we = 1'b0; lc_wa = '0; lc_wd = '0;
        ri    = '0;
        unique case (r_state)
            S_CLR: begin
                lc_we = 1'b1;
                lc_wa = r_n[NIW-1:0];
            end
            S_IDLE: begin
                rs_we = in_acc && (i_in_word.action == ACT_ROW_WR)
                        && (node32 <= MAX_NODES);
                e_we  = in_acc && (i_in_word.action == ACT_EDGE_WR)
                        && (slot32 < MAX_EDGES);
            end
            S_SA: begin
                ri    = 32'(r_in.node);
                rs_re = 1'b1; rs_ra = ri[RIW-1:0];
                lc_re = 1'b1; lc_ra = ri[NIW-1:0];
            end
            S_SB: begin
                ri    = 32'(r_in.node) + 32'd1;
                rs_re = 1'b1; rs_ra = ri[RIW-1:0];
            end
            S_SE: begin
                e_re = 1'b1; e_ra = pick[EW-1:0];
            end
            S_PA: begin
                rs_re = 1'b1; rs_ra = n32[RIW-1:0];
            end
            S_PB: begin
                ri    = n32 + 32'd1;
                rs_re = 1'b1; rs_ra = ri[RIW-1:0];
            end
            S_PL: begin
                e_re  = (r_lo < r_hi);
                e_ra  = a_addr[EW-1:0];
                lc_we = !(r_lo < r_hi);
                lc_wa = r_n[NIW-1:0];
                ri    = 32'(r_lo);
                lc_wd = ri[LC_W-1:0];
            end
            S_PD: begin
                e_re = (r_e_rd.owner != r_pid);
                e_ra = b_addr[EW-1:0];
            end
            S_PE: begin
                e_we = 1'b1; e_wa = a_addr[EW-1:0]; e_wd = r_e_rd;
            end
            S_PF: begin
                e_we = 1'b1; e_wa = b_addr[EW-1:0]; e_wd = r_adata;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rs_we) rs_mem[rs_wa] <= i_in_word.row_start;
        if (rs_re) r_rs_rd <= rs_mem[rs_ra];
    end

    always_ff @(posedge i_clk) begin
        if (e_we) e_mem[e_wa] <= e_wd;
        if (e_re) r_e_rd <= e_mem[e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lc_we) lc_mem[lc_wa] <= lc_wd;
        if (lc_re) r_lc_rd <= lc_mem[lc_ra];
    end

    // ---- sequencer ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (n32 == MAX_NODES - 1) n_state = S_IDLE;
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_word.action)
                        ACT_SAMPLE: n_state = node_bad ? S_OUT : S_SA;
                        ACT_SPLIT:  n_state = (active == '0) ? S_IDLE : S_PA;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_SA:  n_state = S_SB;
            S_SB:  n_state = S_SC;
            S_SC:  n_state = (deg_c == '0) ? S_OUT : S_DIV;
            S_DIV: if (r_cnt == '0) n_state = S_SE;
            S_SE:  n_state = S_SF;
            S_SF:  n_state = S_OUT;
            S_OUT: if (out_load) n_state = S_IDLE;
            S_PA:  n_state = S_PB;
            S_PB:  n_state = S_PC;
            S_PC:  n_state = S_PL;
            S_PL: begin
                if (r_lo < r_hi) n_state = S_PD;
                else if (n32 + 32'd1 == act32) n_state = S_IDLE;
                else n_state = S_PA;
            end
            S_PD:  n_state = (r_e_rd.owner == r_pid) ? S_PL : S_PE;
            S_PE:  n_state = S_PF;
            S_PF:  n_state = S_PL;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_load) r_out_valid <= 1'b1;
            else if (i_out_ready)             r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLR:  r_n <= r_n + NW'(1);
                S_IDLE: r_n <= '0;
                S_PL:   if (!(r_lo < r_hi)) r_n <= r_n + NW'(1);
                default: ;
            endcase
        end
    end

    // APB registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid   <= '0;
            r_ratio <= '0;
            r_ncnt  <= '0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (t_reg_idx'(paddr[3:2]))
                REG_PARTITION_ID: r_pid   <= pwdata[7:0];
                REG_LOCAL_RATIO:  r_ratio <= pwdata[16:0];
                REG_NODE_COUNT:   r_ncnt  <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_PARTITION_ID: prdata = 32'(r_pid);
            REG_LOCAL_RATIO:  prdata = 32'(r_ratio);
            REG_NODE_COUNT:   prdata = 32'(r_ncnt);
            default:          prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_in  <= i_in_word;
                r_res <= '{sampled_node: '0, sampled_owner: '0, invalid: 1'b1};
            end
            S_SB, S_PB: r_start <= clamp_edge(r_rs_rd);
            S_SC: begin
                r_deg   <= deg_c;
                r_div_d <= cand_c;
                r_rem   <= '0;
                r_q     <= r_in.rand_offset;
                r_cnt   <= 5'(ROFF_W - 1);
                r_res   <= '{sampled_node: r_in.node[11:0], sampled_owner: r_pid,
                             invalid: 1'b0};
            end
            S_DIV: begin
                r_rem <= rem_c;
                r_q   <= {r_q[ROFF_W-2:0], 1'b0};
                r_cnt <= r_cnt - 5'd1;
            end
            S_SF: r_res <= '{sampled_node: r_e_rd.neighbor, sampled_owner: r_e_rd.owner,
                             invalid: 1'b0};
            S_OUT: if (out_load) r_out <= r_res;
            S_PC: begin
                r_deg <= deg_c;
                r_lo  <= '0;
                r_hi  <= deg_c;
            end
            S_PD: begin
                r_adata <= r_e_rd;
                if (r_e_rd.owner == r_pid) r_lo <= r_lo + LW'(1);
            end
            S_PF: r_hi <= r_hi - LW'(1);
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // ---- checks ----
    `CSRS_ASSERT_IMP(a_rem_below_div, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_div_d)
    `CSRS_ASSERT_IMP(a_pick_in_row, i_clk, i_rst_n, r_state == S_SE, r_rem < r_deg)
    `CSRS_ASSERT_IMP(a_split_order, i_clk, i_rst_n, r_state == S_PL, r_lo <= r_hi)
    `CSRS_ASSERT_NXT(a_swap_returns, i_clk, i_rst_n, r_state == S_PF, r_state == S_PL)
    `CSRS_ASSERT_IMP(a_out_from_seq, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state == S_OUT))

endmodule
